/* rtl/core/b2s_pkg.sv */
// ----------------------------------------------------------------------------
// b2s_pkg
// Shared widths, register indexes and types of the batch-to-space address map.
// ----------------------------------------------------------------------------
package b2s_pkg;

  // field and register widths
  localparam int NW      = 8;
  localparam int YW      = 16;
  localparam int CW      = 12;
  localparam int BatchW  = 9;
  localparam int DimW    = 13;
  localparam int BlkW    = 5;
  localparam int CropW   = 8;
  localparam int OffW    = 32;
  localparam int AddrW   = 5;
  localparam int DataW   = 32;

  // cropped coordinate, also the dividend of the row and column split
  localparam int DivW        = YW + 1;
  localparam int DivStepsA   = 6;
  localparam int DivStepsB   = 6;
  localparam int DivStepsC   = DivW - DivStepsA - DivStepsB;
  localparam int DivStepsMax = 6;

  // offset datapath widths
  localparam int SubW     = 2 * BlkW + 1;
  localparam int BatchInW = SubW + BatchW + 1;
  localparam int RowProdW = BatchInW + DimW + 1;
  localparam int WideW    = OffW + DimW + 1;

  // cycles from an accepted word to its result strobe
  localparam int Latency = 10;

  typedef logic [2:0] reg_idx_t;

  localparam reg_idx_t RegOutBatch = 3'd0;
  localparam reg_idx_t RegInHeight = 3'd1;
  localparam reg_idx_t RegInWidth  = 3'd2;
  localparam reg_idx_t RegChannels = 3'd3;
  localparam reg_idx_t RegBlockH   = 3'd4;
  localparam reg_idx_t RegBlockW   = 3'd5;
  localparam reg_idx_t RegCropTop  = 3'd6;
  localparam reg_idx_t RegCropLeft = 3'd7;

  typedef struct packed {
    logic [DivW-1:0] quo;
    logic [BlkW-1:0] rem;
  } div_result_t;

endpackage

/* rtl/core/b2s_divider.sv */
// ----------------------------------------------------------------------------
// b2s_divider
// Three-stage restoring divider, 17-bit dividend by a 5-bit divisor.
// ----------------------------------------------------------------------------
module b2s_divider (
  input  logic                       clk,
  input  logic [b2s_pkg::DivW-1:0]   dividend,
  input  logic [b2s_pkg::BlkW-1:0]   divisor,
  output b2s_pkg::div_result_t       result
);
  import b2s_pkg::*;

  // shift register form: dividend bits leave at the top, quotient bits enter below
  function automatic logic [BlkW+DivW-1:0] div_steps(
    input logic [BlkW-1:0] rem_in,
    input logic [DivW-1:0] work_in,
    input logic [BlkW-1:0] dv,
    input int unsigned     steps
  );
    logic [BlkW:0]   r6;
    logic [BlkW-1:0] r;
    logic [DivW-1:0] w;
    logic            ge;
    r  = rem_in;
    w  = work_in;
    r6 = '0;
    ge = 1'b0;
    for (int i = 0; i < DivStepsMax; i++) begin
      if (i < steps) begin
        r6 = {r, w[DivW-1]};
        ge = (r6 >= {1'b0, dv});
        w  = {w[DivW-2:0], ge};
        r  = ge ? BlkW'(r6 - {1'b0, dv}) : r6[BlkW-1:0];
      end
    end
    return {r, w};
  endfunction

  logic [BlkW-1:0] rem_a, rem_b, rem_c;
  logic [DivW-1:0] work_a, work_b, work_c;

  always_ff @(posedge clk) begin
    {rem_a, work_a} <= div_steps('0, dividend, divisor, DivStepsA);
    {rem_b, work_b} <= div_steps(rem_a, work_a, divisor, DivStepsB);
    {rem_c, work_c} <= div_steps(rem_b, work_b, divisor, DivStepsC);
  end

  assign result.quo = work_c;
  assign result.rem = rem_c;

endmodule

/* rtl/core/batch_to_space_address_map.sv */
// throughput: one word per cycle, sustained; busy is high only during reset
// stages: crop add, the 17-step row/column divider (3 stages), range check,
// batch index multiply-add, three offset multiply-adds and the output register
// reset: synchronous, clears the pipeline valid bits and loads register defaults
// results cannot be held off: done is a one-cycle strobe
// ----------------------------------------------------------------------------
// batch_to_space_address_map
// Maps an output coordinate of a batch-to-space rearrangement to the flat
// NHWC offset of its source element, with a range flag.
// ----------------------------------------------------------------------------
module batch_to_space_address_map (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [b2s_pkg::NW-1:0]      out_n,
  input  logic [b2s_pkg::YW-1:0]      out_y,
  input  logic [b2s_pkg::YW-1:0]      out_x,
  input  logic [b2s_pkg::CW-1:0]      out_c,
  output logic                        done,
  output logic [b2s_pkg::OffW-1:0]    source_offset,
  output logic                        in_range,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [b2s_pkg::AddrW-1:0]   paddr,
  input  logic [b2s_pkg::DataW-1:0]   pwdata,
  output logic [b2s_pkg::DataW-1:0]   prdata,
  output logic                        pready
);
  import b2s_pkg::*;

  // configuration registers
  logic [BatchW-1:0] out_batch;
  logic [DimW-1:0]   in_height;
  logic [DimW-1:0]   in_width;
  logic [DimW-1:0]   channels;
  logic [BlkW-1:0]   block_h;
  logic [BlkW-1:0]   block_w;
  logic [CropW-1:0]  crop_top;
  logic [CropW-1:0]  crop_left;

  reg_idx_t reg_idx;
  logic     cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[AddrW-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_batch <= BatchW'(1);
      in_height <= DimW'(1);
      in_width  <= DimW'(1);
      channels  <= DimW'(1);
      block_h   <= BlkW'(1);
      block_w   <= BlkW'(1);
      crop_top  <= '0;
      crop_left <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        RegOutBatch: out_batch <= pwdata[BatchW-1:0];
        RegInHeight: in_height <= pwdata[DimW-1:0];
        RegInWidth:  in_width  <= pwdata[DimW-1:0];
        RegChannels: channels  <= pwdata[DimW-1:0];
        RegBlockH:   block_h   <= pwdata[BlkW-1:0];
        RegBlockW:   block_w   <= pwdata[BlkW-1:0];
        RegCropTop:  crop_top  <= pwdata[CropW-1:0];
        RegCropLeft: crop_left <= pwdata[CropW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegOutBatch: prdata = DataW'(out_batch);
      RegInHeight: prdata = DataW'(in_height);
      RegInWidth:  prdata = DataW'(in_width);
      RegChannels: prdata = DataW'(channels);
      RegBlockH:   prdata = DataW'(block_h);
      RegBlockW:   prdata = DataW'(block_w);
      RegCropTop:  prdata = DataW'(crop_top);
      RegCropLeft: prdata = DataW'(crop_left);
    endcase
  end

  // pipeline never stalls, so input is refused only in reset
  logic accept;
  assign busy   = rst;
  assign accept = start && !busy;

  // stage valid bits, stage 1 through stage 9
  logic [8:0] vld;

  // stage 1: crops added
  logic [DivW-1:0] yc1, xc1;
  logic [NW-1:0]   n1, n2, n3, n4, n5;
  logic [CW-1:0]   c1, c2, c3, c4, c5, c6, c7, c8;

  // divider outputs line up with stage 4
  div_result_t ydiv, xdiv;

  // stage 5 onward
  logic [SubW-1:0]     sub5;
  logic                bad5, bad6, bad7, bad8, bad9;
  logic [DimW-1:0]     row5, row6;
  logic [DimW-1:0]     col5, col6, col7;
  logic [BatchInW-1:0] b6;
  logic [RowProdW-1:0] p7;
  logic [WideW-1:0]    p8, p9;
  logic                ovf8, ovf9;
  logic                ok9;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[7:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    yc1 <= DivW'(out_y) + DivW'(crop_top);
    xc1 <= DivW'(out_x) + DivW'(crop_left);
    n1  <= out_n;
    c1  <= out_c;
    {n2, n3, n4} <= {n1, n2, n3};
    {c2, c3, c4} <= {c1, c2, c3};
  end

  b2s_divider u_ydiv (
    .clk      (clk),
    .dividend (yc1),
    .divisor  (block_h),
    .result   (ydiv)
  );

  b2s_divider u_xdiv (
    .clk      (clk),
    .dividend (xc1),
    .divisor  (block_w),
    .result   (xdiv)
  );

  always_ff @(posedge clk) begin
    // stage 5: range checks and sub-block index
    sub5 <= SubW'(ydiv.rem) * SubW'(block_w) + SubW'(xdiv.rem);
    bad5 <= (block_h == '0) || (block_w == '0) ||
            (BatchW'(n4) >= out_batch) ||
            (ydiv.quo >= DivW'(in_height)) ||
            (xdiv.quo >= DivW'(in_width)) ||
            (DimW'(c4) >= channels);
    row5 <= ydiv.quo[DimW-1:0];
    col5 <= xdiv.quo[DimW-1:0];
    n5   <= n4;
    c5   <= c4;

    // stage 6: input batch index
    b6   <= BatchInW'(sub5) * BatchInW'(out_batch) + BatchInW'(n5);
    row6 <= row5;
    col6 <= col5;
    c6   <= c5;
    bad6 <= bad5;

    // stage 7: times height plus row
    p7   <= RowProdW'(b6) * RowProdW'(in_height) + RowProdW'(row6);
    col7 <= col6;
    c7   <= c6;
    bad7 <= bad6;

    // stage 8: times width plus column; an overflow here stays an overflow
    p8   <= WideW'(p7[OffW-1:0]) * WideW'(in_width) + WideW'(col7);
    ovf8 <= |p7[RowProdW-1:OffW];
    c8   <= c7;
    bad8 <= bad7;

    // stage 9: times channels plus channel
    p9   <= WideW'(p8[OffW-1:0]) * WideW'(channels) + WideW'(c8);
    ovf9 <= ovf8 || (|p8[WideW-1:OffW]);
    bad9 <= bad8;
  end

  assign ok9 = !bad9 && !ovf9 && !(|p9[WideW-1:OffW]);

  // stage 10: result word
  always_ff @(posedge clk) begin
    if (rst) begin
      done          <= 1'b0;
      in_range      <= 1'b0;
      source_offset <= '0;
    end else begin
      done          <= vld[8];
      in_range      <= vld[8] && ok9;
      source_offset <= (vld[8] && ok9) ? p9[OffW-1:0] : '0;
    end
  end

endmodule

/* rtl/core/b2s_checker.sv */
// ----------------------------------------------------------------------------
// b2s_checker
// Port-level assertions for the batch-to-space address map, bound to the top.
// ----------------------------------------------------------------------------
module b2s_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic [b2s_pkg::OffW-1:0]    source_offset,
  input logic                        in_range,
  input logic                        pready
);
  import b2s_pkg::*;

  // every accepted word yields exactly one strobe after the fixed latency
  a_word_gives_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##Latency done)
    else $error("accepted word produced no result");

  a_no_invented_result: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, Latency))
    else $error("result strobe without an accepted word");

  // a rejected coordinate reports a zero offset
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !in_range) |-> (source_offset == '0))
    else $error("out-of-range result carries a nonzero offset");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !done |-> (!in_range && source_offset == '0))
    else $error("result ports active without a strobe");

  a_pready_high: assert property (@(posedge clk) pready)
    else $error("register port not ready");

endmodule

bind batch_to_space_address_map b2s_checker u_b2s_checker (.*);
